>>> sv/hashed_reference_count_table_assert.svh
// assertion macros for the hashed reference count table checker
`ifndef HASHED_REFERENCE_COUNT_TABLE_ASSERT_SVH
`define HASHED_REFERENCE_COUNT_TABLE_ASSERT_SVH

// clocked assertion, off while reset is low
`define HRCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// same-cycle implication
`define HRCT_ASSERT_IMP(lbl, ante, cons, msg) \
    `HRCT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> sv/hrct_pkg.sv
// shared codes and field layout of the hashed reference count table
package hrct_pkg;

    localparam int OPCODE_W    = 2;
    localparam int KEY_W       = 48;
    localparam int REF_COUNT_W = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 40;

    localparam logic [OPCODE_W-1:0] OP_RETAIN  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_NEW     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

endpackage

>>> sv/hashed_reference_count_table.sv
// hashed reference count table top level: sequencer, bucket memories and result register
// Keeps a reference count per object key in NUM_BUCKETS buckets of WAYS entries. After reset
// the block clears the valid rows, one bucket a cycle, before s_tready first rises. Each beat
// is then accepted and gets its bucket index (a mask when NUM_BUCKETS is a power of two, else
// the reciprocal-multiply modulo unit, one 16-bit key chunk at a time). Its bucket is scanned
// way by way through the single-port entry memory, a read state then a compare state per way
// (the scan stops at a key match), and then the bucket is updated and the result loaded. One
// beat is in work at a time; the result register lets the next beat start while a result
// still waits on m_tready.
module hashed_reference_count_table import hrct_pkg::*; #(
    parameter int NUM_BUCKETS = 1024,
    parameter int WAYS        = 4,
    parameter int KEY_BITS    = 48,
    parameter int COUNT_BITS  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // opcode[1:0], object_key[49:2], zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // ref_count[31:0], reached_zero[32], status[34:33]
);

    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DEPTH = NUM_BUCKETS * WAYS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BKW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_ACT   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [BKW-1:0]        clr_reg;
    logic [WW-1:0]         way_reg;
    logic [OPCODE_W-1:0]   op_reg;
    logic [KW-1:0]         key_reg;
    logic [AW-1:0]         base_reg;
    logic                  hit_reg;
    logic [WW-1:0]         hit_way_reg;
    logic [COUNT_BITS-1:0] hcnt_reg;
    logic                  free_reg;
    logic [WW-1:0]         free_way_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [KW-1:0]         key_mem [DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
    logic [WAYS-1:0]       vld_mem [NUM_BUCKETS];
    logic [KW-1:0]         ekey_q;
    logic [COUNT_BITS-1:0] ecnt_q;
    logic [WAYS-1:0]       vrow_q;

    logic                  s_fire;
    logic                  mod_busy;
    logic [BKW-1:0]        bucket;
    logic                  fire_out;
    logic                  last_way;
    logic                  way_hit;

    logic                  e_we;
    logic [AW-1:0]         e_addr;
    logic [COUNT_BITS-1:0] e_cnt;
    logic [WW-1:0]         sel_way;
    logic                  v_we;
    logic [BKW-1:0]        v_addr;
    logic [WAYS-1:0]       v_wdata;

    logic                  act_ewe;
    logic                  act_vwe;
    logic [WW-1:0]         act_way;
    logic [COUNT_BITS-1:0] res_cnt;
    logic                  res_zero;
    logic [STATUS_W-1:0]   res_st;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign fire_out = (state_reg == S_ACT) && (!m_tvalid_reg || m_tready);
    assign last_way = (way_reg == WW'(WAYS - 1));
    assign way_hit  = vrow_q[way_reg] && (ekey_q == key_reg);

    hrct_mod #(
        .N   (NUM_BUCKETS),
        .KW  (KW),
        .BKW (BKW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire),
        .key     (s_tdata[OPCODE_W +: KW]),
        .busy    (mod_busy),
        .bucket  (bucket)
    );

    // operation on the scanned bucket
    always_comb begin
        act_ewe  = 1'b0;
        act_vwe  = 1'b0;
        act_way  = hit_way_reg;
        res_cnt  = '0;
        res_zero = 1'b0;
        res_st   = ST_OK;
        case (op_reg)
            OP_RETAIN, OP_NEW: begin
                if (hit_reg) begin
                    act_ewe = 1'b1;
                    if (op_reg == OP_NEW) begin
                        res_cnt = COUNT_BITS'(1);
                    end else if (hcnt_reg == '1) begin
                        res_cnt = hcnt_reg;
                    end else begin
                        res_cnt = hcnt_reg + COUNT_BITS'(1);
                    end
                end else if (free_reg) begin
                    act_ewe = 1'b1;
                    act_vwe = 1'b1;
                    act_way = free_way_reg;
                    res_cnt = COUNT_BITS'(1);
                end else begin
                    res_st = ST_FULL;
                end
            end
            OP_QUERY: begin
                if (hit_reg) begin
                    res_cnt = hcnt_reg;
                end else begin
                    res_st = ST_NOT_FOUND;
                end
            end
            default: begin
                if (!hit_reg) begin
                    res_st = ST_NOT_FOUND;
                end else if (hcnt_reg == '0) begin
                    res_st = ST_UNDERFLOW;
                end else begin
                    act_ewe  = 1'b1;
                    res_cnt  = hcnt_reg - COUNT_BITS'(1);
                    res_zero = (hcnt_reg == COUNT_BITS'(1));
                end
            end
        endcase
    end

    assign sel_way = (state_reg == S_ACT) ? act_way : way_reg;
    assign e_addr  = base_reg + AW'(sel_way);
    assign e_we    = fire_out && act_ewe;
    assign e_cnt   = res_cnt;
    assign v_we    = (state_reg == S_CLEAR) || (fire_out && act_vwe);
    assign v_addr  = (state_reg == S_CLEAR) ? clr_reg : bucket;
    assign v_wdata = (state_reg == S_CLEAR) ? '0 : (vrow_q | (WAYS'(1) << free_way_reg));

    always_ff @(posedge aclk) begin
        if (e_we) begin
            key_mem[e_addr] <= key_reg;
            cnt_mem[e_addr] <= e_cnt;
        end
        ekey_q <= key_mem[e_addr];
        ecnt_q <= cnt_mem[e_addr];
    end

    always_ff @(posedge aclk) begin
        if (v_we) begin
            vld_mem[v_addr] <= v_wdata;
        end
        vrow_q <= vld_mem[v_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == BKW'(NUM_BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                if (!mod_busy) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (way_hit || last_way) begin
                    state_next = S_ACT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_ACT: begin
                if (fire_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= fire_out || (m_tvalid_reg && !m_tready);
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + BKW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg  <= s_tdata[OPCODE_W-1:0];
            key_reg <= s_tdata[OPCODE_W +: KW];
        end
        if (state_reg == S_MOD && !mod_busy) begin
            base_reg <= AW'(bucket) * AW'(WAYS);
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        if (state_reg == S_CMP) begin
            if (way_hit) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= way_reg;
                hcnt_reg    <= ecnt_q;
            end else if (!last_way) begin
                way_reg <= way_reg + WW'(1);
            end
            if (!vrow_q[way_reg] && !free_reg) begin
                free_reg     <= 1'b1;
                free_way_reg <= way_reg;
            end
        end
        if (fire_out) begin
            m_tdata_reg <= {(M_TDATA_W - REF_COUNT_W - STATUS_W - 1)'(0), res_st, res_zero,
                            REF_COUNT_W'(res_cnt)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/hrct_mod.sv
// key modulo bucket count unit: a mask for a power-of-two count, else a reciprocal multiply per key chunk
module hrct_mod #(
    parameter int N  = 1024,
    parameter int KW = 48,
    parameter int BKW = 10
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [KW-1:0]  key,
    output logic           busy,
    output logic [BKW-1:0] bucket
);

    localparam bit          IS_POW2 = ((N & (N - 1)) == 0);
    localparam int          NCH     = (KW + 15) / 16;
    localparam int          PW      = NCH * 16;
    localparam int          CW      = $clog2(NCH + 1);
    localparam logic [63:0] RECIP   = IS_POW2 ? 64'd0 : ((64'd1 << 32) / 64'(N));

    localparam logic [1:0] PH_MUL_R = 2'd0;
    localparam logic [1:0] PH_MUL_N = 2'd1;
    localparam logic [1:0] PH_FIX   = 2'd2;

    logic           busy_reg;
    logic [1:0]     ph_reg;
    logic [CW-1:0]  cnt_reg;
    logic [PW-1:0]  sh_reg;
    logic [BKW-1:0] rem_reg;
    logic [31:0]    d_reg;
    logic [63:0]    prod_reg;
    logic [31:0]    dividend;
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    mul_p;
    logic [31:0]    diff;
    logic [16:0]    rem_est;
    logic [16:0]    rem_fix;

    // one shared multiplier: quotient estimate, then quotient times bucket count
    always_comb begin
        dividend = (32'(rem_reg) << 16) | 32'(sh_reg[PW-1 -: 16]);
        if (ph_reg == PH_MUL_R) begin
            mul_a = dividend;
            mul_b = RECIP[31:0];
        end else begin
            mul_a = prod_reg[63:32];
            mul_b = 32'(N);
        end
        mul_p   = 64'(mul_a) * 64'(mul_b);
        diff    = d_reg - prod_reg[31:0];
        rem_est = diff[16:0];
        if (rem_est >= 17'(N)) begin
            rem_fix = rem_est - 17'(N);
        end else begin
            rem_fix = rem_est;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= !IS_POW2;
        end else if (busy_reg && ph_reg == PH_FIX && cnt_reg == CW'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= PW'(key);
            cnt_reg <= CW'(NCH);
            ph_reg  <= PH_MUL_R;
            if (IS_POW2) begin
                rem_reg <= (N == 1) ? '0 : key[BKW-1:0];
            end else begin
                rem_reg <= '0;
            end
        end else if (busy_reg) begin
            case (ph_reg)
                PH_MUL_R: begin
                    d_reg    <= dividend;
                    prod_reg <= mul_p;
                    sh_reg   <= sh_reg << 16;
                    ph_reg   <= PH_MUL_N;
                end
                PH_MUL_N: begin
                    prod_reg <= mul_p;
                    ph_reg   <= PH_FIX;
                end
                PH_FIX: begin
                    rem_reg <= BKW'(rem_fix);
                    cnt_reg <= cnt_reg - CW'(1);
                    ph_reg  <= PH_MUL_R;
                end
                default: begin
                    ph_reg <= PH_MUL_R;
                end
            endcase
        end
    end

    assign busy   = busy_reg;
    assign bucket = rem_reg;

endmodule

>>> sv/hrct_check.sv
// port-level checker for the hashed reference count table, bound to the top level
`include "hashed_reference_count_table_assert.svh"

module hrct_check import hrct_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // error results carry no count and no zero flag
    `HRCT_ASSERT_IMP(a_err_no_count, m_tvalid && (m_tdata[34:33] != ST_OK), (m_tdata[31:0] == 32'd0) && !m_tdata[32], "error beat with nonzero count or zero flag")

    // zero flag only on a clean release down to zero
    `HRCT_ASSERT_IMP(a_zero_clean, m_tvalid && m_tdata[32], (m_tdata[34:33] == ST_OK) && (m_tdata[31:0] == 32'd0), "zero flag with bad status or count")

    // the input never takes beats on consecutive cycles
    `HRCT_ASSERT(a_one_in_work, s_tvalid && s_tready |=> !s_tready, "input taken on consecutive cycles")

    `HRCT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result beat changed")

endmodule

bind hashed_reference_count_table hrct_check u_hrct_check (.*);
